### rtl/lsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsp_pkg: shared types and constants for the lidar sample to point converter
// Fixed-point constants, reciprocal multipliers, column sine/cosine tables, codes.
// ----------------------------------------------------------------------------
package lsp_pkg;

  localparam int COLUMNS      = 900;
  localparam int CHANNELS     = 4;
  localparam int COL_QUAD     = COLUMNS / 4;          // columns per quadrant
  localparam int COL_FOLD_MAX = COL_QUAD / 2;         // last column before the 45 deg fold
  localparam int CDEG_PER_COL = 36000 / COLUMNS;

  localparam longint unsigned ONE_Q30 = 64'd1 << 30;
  localparam longint unsigned RAD_PER_CDEG_Q30 = 64'd187403;

  localparam logic [39:0] R_CONST_Q20   = 40'd1230812546;
  localparam logic [23:0] LOG2_COEF_Q16 = 24'd10493428;

  // floor(n/5) = (n * DIV5_RCP) >> DIV5_SH for n < 2^20
  localparam logic [20:0] DIV5_RCP = 21'((64'd1 << 23) / 5 + 1);
  localparam int          DIV5_SH  = 23;

  // Horner divisors as reciprocals, exact for dividends below 2^30
  localparam logic [31:0] SIN_RCP [0:5] = '{
    32'((64'd1 << 37) / 110 + 1), 32'((64'd1 << 37) / 72 + 1),
    32'((64'd1 << 36) / 42 + 1),  32'((64'd1 << 35) / 20 + 1),
    32'((64'd1 << 33) / 6 + 1),   32'd0};
  localparam int SIN_SH [0:5] = '{37, 37, 36, 35, 33, 30};
  localparam logic [31:0] COS_RCP [0:5] = '{
    32'((64'd1 << 38) / 132 + 1), 32'((64'd1 << 37) / 90 + 1),
    32'((64'd1 << 36) / 56 + 1),  32'((64'd1 << 35) / 30 + 1),
    32'((64'd1 << 34) / 12 + 1),  32'((64'd1 << 31) / 2 + 1)};
  localparam int COS_SH [0:5] = '{38, 37, 36, 35, 34, 31};

  localparam int PIPE_OUT = 27;            // stage index of the result registers
  localparam int LATENCY  = PIPE_OUT + 1;  // start transfer to done, in cycles

  typedef struct packed {
    logic [30:0] s;
    logic        sn;
    logic [30:0] c;
    logic        cn;
  } sc_t;

  typedef enum logic [2:0] {
    REG_RANGE_MIN, REG_RANGE_MAX, REG_GROUND_ON, REG_BASE_HEIGHT,
    REG_TILT0, REG_TILT1, REG_TILT2, REG_TILT3
  } cfg_reg_t;

  typedef enum logic [1:0] {ST_OK, ST_RANGE, ST_GROUND, ST_BADCH} status_t;

  typedef logic [30:0] qtab_t [0:COL_FOLD_MAX];

  // quadrant mapping of first-octant sine/cosine magnitudes
  function automatic sc_t quad_map(input logic [1:0] q, input logic [30:0] bs,
                                   input logic [30:0] bc);
    sc_t o;
    unique case (q)
      2'd0: o = '{s: bs, sn: 1'b0, c: bc, cn: 1'b0};
      2'd1: o = '{s: bc, sn: 1'b0, c: bs, cn: 1'b1};
      2'd2: o = '{s: bs, sn: 1'b1, c: bc, cn: 1'b1};
      2'd3: o = '{s: bc, sn: 1'b1, c: bs, cn: 1'b0};
    endcase
    return o;
  endfunction

  // elaboration-time series, used only to build the column tables
  function automatic logic [30:0] ser_sin(input longint unsigned x);
    longint unsigned x2, t;
    x2 = (x * x) >> 30;
    t = ONE_Q30 - x2 / 110;
    t = ONE_Q30 - ((x2 * t) >> 30) / 72;
    t = ONE_Q30 - ((x2 * t) >> 30) / 42;
    t = ONE_Q30 - ((x2 * t) >> 30) / 20;
    t = ONE_Q30 - ((x2 * t) >> 30) / 6;
    return 31'((x * t) >> 30);
  endfunction

  function automatic logic [30:0] ser_cos(input longint unsigned x);
    longint unsigned x2, t;
    x2 = (x * x) >> 30;
    t = ONE_Q30 - x2 / 132;
    t = ONE_Q30 - ((x2 * t) >> 30) / 90;
    t = ONE_Q30 - ((x2 * t) >> 30) / 56;
    t = ONE_Q30 - ((x2 * t) >> 30) / 30;
    t = ONE_Q30 - ((x2 * t) >> 30) / 12;
    t = ONE_Q30 - ((x2 * t) >> 30) / 2;
    return 31'(t);
  endfunction

  function automatic qtab_t make_tab(input bit want_cos);
    qtab_t tb;
    longint unsigned x;
    for (int k = 0; k <= COL_FOLD_MAX; k++) begin
      x = longint'(k) * CDEG_PER_COL * RAD_PER_CDEG_Q30;
      tb[k] = want_cos ? ser_cos(x) : ser_sin(x);
    end
    return tb;
  endfunction

  localparam qtab_t COL_SIN_TAB = make_tab(1'b0);
  localparam qtab_t COL_COS_TAB = make_tab(1'b1);

  // floor(k * 2^19 / 5)
  function automatic logic [18:0] fifth_q19(input logic [2:0] k);
    logic [18:0] v;
    case (k)
      3'd1:    v = 19'd104857;
      3'd2:    v = 19'd209715;
      3'd3:    v = 19'd314572;
      3'd4:    v = 19'd419430;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

### rtl/lsp_sincos.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsp_sincos: pipelined sine/cosine of an angle in hundredths of a degree
// Quadrant reduction, fold to 45 deg, Horner series; 17 register stages.
// ----------------------------------------------------------------------------
module lsp_sincos (
  input  logic             clk,
  input  logic [15:0]      ang,   // 0..35999
  output lsp_pkg::sc_t     res
);

  logic [1:0]  q1;
  logic        f1;
  logic [12:0] xr1;
  logic [1:0]  q2, q3;
  logic        f2, f3;
  logic [29:0] x2r, x3, xsq3;

  // step pipeline: index j is the input of step j
  logic [30:0] ts [0:6];
  logic [30:0] tc [0:6];
  logic [29:0] xb [0:6];
  logic [29:0] x2b [0:6];
  logic [1:0]  qb [0:6];
  logic        fb [0:6];
  logic [29:0] vs [0:5];
  logic [29:0] vc [0:5];
  logic [29:0] xa [0:5];
  logic [29:0] x2a [0:5];
  logic [1:0]  qa [0:5];
  logic        fa [0:5];

  logic [1:0]  q_c;
  logic [13:0] rem_c;

  always_comb begin
    priority if (ang < 16'd9000) begin
      q_c = 2'd0; rem_c = 14'(ang);
    end else if (ang < 16'd18000) begin
      q_c = 2'd1; rem_c = 14'(ang - 16'd9000);
    end else if (ang < 16'd27000) begin
      q_c = 2'd2; rem_c = 14'(ang - 16'd18000);
    end else begin
      q_c = 2'd3; rem_c = 14'(ang - 16'd27000);
    end
  end

  always_ff @(posedge clk) begin
    q1  <= q_c;
    f1  <= rem_c > 14'd4500;
    xr1 <= (rem_c > 14'd4500) ? 13'(14'd9000 - rem_c) : 13'(rem_c);

    q2  <= q1;
    f2  <= f1;
    x2r <= 30'(31'(xr1) * 31'(lsp_pkg::RAD_PER_CDEG_Q30));

    q3   <= q2;
    f3   <= f2;
    x3   <= x2r;
    xsq3 <= 30'((60'(x2r) * 60'(x2r)) >> 30);

    ts[0]  <= 31'(lsp_pkg::ONE_Q30);
    tc[0]  <= 31'(lsp_pkg::ONE_Q30);
    xb[0]  <= x3;
    x2b[0] <= xsq3;
    qb[0]  <= q3;
    fb[0]  <= f3;

    for (int j = 0; j < 6; j++) begin
      // multiply half of the step
      if (j == 5) begin
        vs[j] <= 30'((61'(xb[j]) * 61'(ts[j])) >> 30);
      end else begin
        vs[j] <= 30'((61'(x2b[j]) * 61'(ts[j])) >> 30);
      end
      vc[j]  <= 30'((61'(x2b[j]) * 61'(tc[j])) >> 30);
      xa[j]  <= xb[j];
      x2a[j] <= x2b[j];
      qa[j]  <= qb[j];
      fa[j]  <= fb[j];
      // divide-and-subtract half
      if (j == 5) begin
        ts[j+1] <= 31'(vs[j]);
      end else begin
        ts[j+1] <= 31'(lsp_pkg::ONE_Q30) -
                   31'((62'(vs[j]) * 62'(lsp_pkg::SIN_RCP[j])) >> lsp_pkg::SIN_SH[j]);
      end
      tc[j+1]  <= 31'(lsp_pkg::ONE_Q30) -
                  31'((62'(vc[j]) * 62'(lsp_pkg::COS_RCP[j])) >> lsp_pkg::COS_SH[j]);
      xb[j+1]  <= xa[j];
      x2b[j+1] <= x2a[j];
      qb[j+1]  <= qa[j];
      fb[j+1]  <= fa[j];
    end

    // folded: the cosine series gives the sine and vice versa
    res <= lsp_pkg::quad_map(qb[6], fb[6] ? tc[6] : ts[6], fb[6] ? ts[6] : tc[6]);
  end

endmodule

### rtl/lidar_sample_to_point.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lidar_sample_to_point: raw lidar sample to Cartesian point, fixed point
// Range correction via log2, range and ground tests, spherical to x/y/z.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive channel, column, distance_mm with start high; the sample
//   transfers on a rising edge with start high and busy low. busy is high
//   only during reset, so one sample can transfer every clock.
//   Output: done pulses for one cycle with point_x/y/z (1/16 mm, two's
//   complement) and status. Exactly one result per sample, in order.
//   Pipeline: a sample passes 27 pipeline stages and then the result
//   register, where done is registered with point_x/y/z and status (the
//   log2 chain of 20 squarings, one per stage, sets the depth).
//   Throughput: one sample per cycle, set by the fully pipelined datapath.
//   The receiver cannot stall; results are presented once and not held.
//   Config: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is
//   always high. Write only while no sample is in flight.
//   Reset: synchronous, clears the valid pipeline and restores register
//   defaults (range 0..100000 mm, ground removal off, tilts zero).
// ----------------------------------------------------------------------------
module lidar_sample_to_point (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [7:0]         channel,
  input  logic [9:0]         column,
  input  logic [15:0]        distance_mm,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [17:0]        cfg_data,
  output logic               done,
  output logic signed [21:0] point_x,
  output logic signed [21:0] point_y,
  output logic signed [21:0] point_z,
  output logic [1:0]         status
);

  localparam int LAST = lsp_pkg::PIPE_OUT - 1;

  typedef struct packed {
    logic              bad_ch;
    logic              dzero;
    logic              tnz;
    logic [15:0]       tang;
    logic [9:0]        col;
    logic [15:0]       d;
    logic [9:0]        cm;
    logic [1:0]        cq;
    logic [6:0]        ck;
    logic              cfold;
    logic [30:0]       cbs;
    logic [30:0]       cbc;
    lsp_pkg::sc_t      col_sc;
    logic [19:0]       a11;
    logic [19:0]       q5;
    logic [36:0]       big_a;
    logic [3:0]        e;
    logic [30:0]       m;
    logic [19:0]       frac;
    logic [31:0]       blog;
    logic [37:0]       r;
    logic              oor;
    logic [25:0]       r_q8;
    lsp_pkg::sc_t      tilt_sc;
    logic [25:0]       zmag;
    logic [25:0]       rc;
    logic [25:0]       xm;
    logic [25:0]       ym;
    logic              gnd;
  } rec_t;

  // configuration registers
  logic [17:0]        range_min_mm, range_max_mm;
  logic               ground_removal_on;
  logic [15:0]        base_height_mm;
  logic signed [14:0] tilt_ch [0:3];

  logic         accept;
  logic [LAST:0] vld;
  rec_t         rec [0:LAST];
  rec_t         rec_next [0:LAST];
  lsp_pkg::sc_t tilt_res;

  logic signed [14:0] tilt_sel;
  logic signed [16:0] tilt_x;
  logic [3:0]         e0;
  logic [61:0]        sq  [1:20];
  logic [31:0]        sqh [1:20];
  logic [1:0]         cq_c;
  logic [7:0]         kr_c;
  logic signed [39:0] r_s;

  assign busy      = rst;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      range_min_mm      <= '0;
      range_max_mm      <= 18'd100000;
      ground_removal_on <= 1'b0;
      base_height_mm    <= '0;
      for (int i = 0; i < 4; i++) tilt_ch[i] <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (lsp_pkg::cfg_reg_t'(cfg_index))
        lsp_pkg::REG_RANGE_MIN:   range_min_mm      <= cfg_data;
        lsp_pkg::REG_RANGE_MAX:   range_max_mm      <= cfg_data;
        lsp_pkg::REG_GROUND_ON:   ground_removal_on <= cfg_data[0];
        lsp_pkg::REG_BASE_HEIGHT: base_height_mm    <= cfg_data[15:0];
        lsp_pkg::REG_TILT0:       tilt_ch[0]        <= cfg_data[14:0];
        lsp_pkg::REG_TILT1:       tilt_ch[1]        <= cfg_data[14:0];
        lsp_pkg::REG_TILT2:       tilt_ch[2]        <= cfg_data[14:0];
        lsp_pkg::REG_TILT3:       tilt_ch[3]        <= cfg_data[14:0];
      endcase
    end
  end

  function automatic logic [3:0] lead_one(input logic [15:0] v);
    logic [3:0] p;
    p = '0;
    for (int i = 1; i < 16; i++) if (v[i]) p = 4'(i);
    return p;
  endfunction

  function automatic logic [21:0] to_field(input logic [25:0] mag, input logic neg);
    logic [21:0] v;
    v = 22'((27'(mag) + 27'd8) >> 4);   // round half away from zero
    return neg ? (~v + 22'd1) : v;
  endfunction

  // tilt of the sample's channel, mapped to 0..35999 cdeg
  assign tilt_sel = tilt_ch[channel[1:0]];
  assign tilt_x   = 17'(tilt_sel);
  assign e0       = lead_one(rec[0].d);

  always_comb begin
    for (int i = 1; i <= 20; i++) begin
      sq[i]  = 62'(rec[i].m) * 62'(rec[i].m);
      sqh[i] = sq[i][61:30];
    end
  end

  // column quadrant and octant fold
  always_comb begin
    priority if (rec[1].cm < 10'(lsp_pkg::COL_QUAD)) begin
      cq_c = 2'd0; kr_c = 8'(rec[1].cm);
    end else if (rec[1].cm < 10'(2 * lsp_pkg::COL_QUAD)) begin
      cq_c = 2'd1; kr_c = 8'(rec[1].cm - 10'(lsp_pkg::COL_QUAD));
    end else if (rec[1].cm < 10'(3 * lsp_pkg::COL_QUAD)) begin
      cq_c = 2'd2; kr_c = 8'(rec[1].cm - 10'(2 * lsp_pkg::COL_QUAD));
    end else begin
      cq_c = 2'd3; kr_c = 8'(rec[1].cm - 10'(3 * lsp_pkg::COL_QUAD));
    end
  end

  assign r_s = $signed({3'b000, rec[22].big_a}) + $signed(lsp_pkg::R_CONST_Q20)
             - $signed({8'b0, rec[22].blog});

  lsp_sincos u_tilt_sc (
    .clk (clk),
    .ang (rec[0].tang),
    .res (tilt_res)
  );

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else     vld <= {vld[LAST-1:0], accept};
  end

  always_comb begin
    for (int k = 1; k <= LAST; k++) rec_next[k] = rec[k-1];

    // stage 0: capture
    rec_next[0]        = '0;
    rec_next[0].bad_ch = channel >= 8'(lsp_pkg::CHANNELS);
    rec_next[0].dzero  = distance_mm == '0;
    rec_next[0].tnz    = tilt_sel != '0;
    rec_next[0].tang   = tilt_sel[14] ? 16'(tilt_x + 17'sd36000) : 16'(tilt_x);
    rec_next[0].col    = column;
    rec_next[0].d      = distance_mm;

    // stage 1: normalize, 1.1*d prep, column wrap
    rec_next[1].e    = e0;
    rec_next[1].m    = 31'(rec[0].d) << (5'd30 - 5'(e0));
    rec_next[1].frac = '0;
    rec_next[1].a11  = 20'(rec[0].d) * 20'd11;
    rec_next[1].cm   = (rec[0].col >= 10'(lsp_pkg::COLUMNS)) ?
                       rec[0].col - 10'(lsp_pkg::COLUMNS) : rec[0].col;

    // stage 2
    rec_next[2].q5    = 20'((41'(rec[1].a11) * 41'(lsp_pkg::DIV5_RCP)) >> lsp_pkg::DIV5_SH);
    rec_next[2].cq    = cq_c;
    rec_next[2].cfold = kr_c > 8'(lsp_pkg::COL_FOLD_MAX);
    rec_next[2].ck    = (kr_c > 8'(lsp_pkg::COL_FOLD_MAX)) ?
                        7'(8'(lsp_pkg::COL_QUAD) - kr_c) : 7'(kr_c);

    // stage 3: floor(d*11*2^20/10), column table read
    rec_next[3].big_a = {rec[2].q5[17:0], 19'b0} +
                        37'(lsp_pkg::fifth_q19(3'(rec[2].a11 - rec[2].q5 * 20'd5)));
    rec_next[3].cbs   = rec[2].cfold ? lsp_pkg::COL_COS_TAB[rec[2].ck]
                                     : lsp_pkg::COL_SIN_TAB[rec[2].ck];
    rec_next[3].cbc   = rec[2].cfold ? lsp_pkg::COL_SIN_TAB[rec[2].ck]
                                     : lsp_pkg::COL_COS_TAB[rec[2].ck];

    // stage 4
    rec_next[4].col_sc = lsp_pkg::quad_map(rec[3].cq, rec[3].cbs, rec[3].cbc);

    // stages 2..21: one log2 fraction bit per stage
    for (int i = 1; i <= 20; i++) begin
      rec_next[i+1].m    = sqh[i][31] ? sqh[i][31:1] : sqh[i][30:0];
      rec_next[i+1].frac = {rec[i].frac[18:0], sqh[i][31]};
    end

    // stage 18: tilt sine/cosine, 17 stages behind the tilt angle register
    rec_next[18].tilt_sc = tilt_res;

    // stage 22
    rec_next[22].blog = 32'((48'({rec[21].e, rec[21].frac}) *
                             48'(lsp_pkg::LOG2_COEF_Q16)) >> 16);

    // stage 23: corrected range in Q20 mm, clamped at zero
    rec_next[23].r = r_s[39] ? '0 : r_s[37:0];

    // stage 24: range window
    rec_next[24].oor  = rec[23].dzero || (rec[23].r > {range_max_mm, 20'b0}) ||
                        (rec[23].r < {range_min_mm, 20'b0});
    rec_next[24].r_q8 = rec[23].r[37:12];

    // stage 25
    rec_next[25].zmag = 26'((57'(rec[24].r_q8) * 57'(rec[24].tilt_sc.s)) >> 30);
    rec_next[25].rc   = 26'((57'(rec[24].r_q8) * 57'(rec[24].tilt_sc.c)) >> 30);

    // stage 26: ground test, horizontal projection
    rec_next[26].gnd = ground_removal_on && rec[25].tnz && rec[25].tilt_sc.sn &&
                       (rec[25].zmag > 26'({base_height_mm, 8'b0}));
    rec_next[26].xm  = 26'((57'(rec[25].rc) * 57'(rec[25].col_sc.s)) >> 30);
    rec_next[26].ym  = 26'((57'(rec[25].rc) * 57'(rec[25].col_sc.c)) >> 30);
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k <= LAST; k++) rec[k] <= rec_next[k];
  end

  // result registers
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= vld[LAST];

    priority if (rec[LAST].bad_ch) begin
      status  <= lsp_pkg::ST_BADCH;
      point_x <= '0;
      point_y <= '0;
      point_z <= '0;
    end else if (rec[LAST].oor) begin
      status  <= lsp_pkg::ST_RANGE;
      point_x <= '0;
      point_y <= '0;
      point_z <= '0;
    end else if (rec[LAST].gnd) begin
      status  <= lsp_pkg::ST_GROUND;
      point_x <= '0;
      point_y <= '0;
      point_z <= '0;
    end else begin
      status  <= lsp_pkg::ST_OK;
      point_x <= $signed(to_field(rec[LAST].xm,
                                  rec[LAST].col_sc.sn ^ rec[LAST].tilt_sc.cn));
      point_y <= $signed(to_field(rec[LAST].ym,
                                  rec[LAST].col_sc.cn ^ rec[LAST].tilt_sc.cn));
      point_z <= $signed(to_field(rec[LAST].zmag, rec[LAST].tilt_sc.sn));
    end
  end

endmodule

### rtl/lsp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsp_props: port-level checks for the lidar sample to point converter
// Fixed latency pairing, rejected-point zeros, bad channel status.
// ----------------------------------------------------------------------------
module lsp_props (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic [7:0]         channel,
  input logic               done,
  input logic [1:0]         status,
  input logic signed [21:0] point_x,
  input logic signed [21:0] point_y,
  input logic signed [21:0] point_z
);

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##(lsp_pkg::LATENCY) done)
    else $error("sample transfer without result");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, lsp_pkg::LATENCY))
    else $error("result without sample transfer");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != lsp_pkg::ST_OK) |-> (point_x == '0 && point_y == '0 && point_z == '0))
    else $error("rejected point has nonzero coordinates");

  a_bad_channel: assert property (@(posedge clk) disable iff (rst)
    done |-> ((status == lsp_pkg::ST_BADCH) ==
              ($past(channel, lsp_pkg::LATENCY) >= 8'(lsp_pkg::CHANNELS))))
    else $error("bad channel status mismatch");

endmodule

bind lidar_sample_to_point lsp_props u_lsp_props (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .channel (channel),
  .done    (done),
  .status  (status),
  .point_x (point_x),
  .point_y (point_y),
  .point_z (point_z)
);

### verif/lsp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsp_checker: scoreboard for the lidar sample to point converter
// Mirrors config writes, predicts each accepted sample, checks each done.
// ----------------------------------------------------------------------------
module lsp_checker
  import lsp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic [7:0]         channel,
  input  logic [9:0]         column,
  input  logic [15:0]        distance_mm,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [17:0]        cfg_data,
  input  logic               done,
  input  logic signed [21:0] point_x,
  input  logic signed [21:0] point_y,
  input  logic signed [21:0] point_z,
  input  logic [1:0]         status,
  output int                 errors,
  output int                 pending,
  output int                 checked
);

  typedef struct {
    logic [21:0] x;
    logic [21:0] y;
    logic [21:0] z;
    status_t     st;
  } point_t;

  typedef longint unsigned u64;

  point_t points_due[$];

  logic [17:0] rmin, rmax;
  logic        gnd_on;
  logic [15:0] base_h;
  logic [14:0] tilt [0:3];

  function automatic u64 sin_poly(u64 x);
    u64 x2, t;
    x2 = (x * x) >> 30;
    t = ONE_Q30 - x2 / 110;
    t = ONE_Q30 - ((x2 * t) >> 30) / 72;
    t = ONE_Q30 - ((x2 * t) >> 30) / 42;
    t = ONE_Q30 - ((x2 * t) >> 30) / 20;
    t = ONE_Q30 - ((x2 * t) >> 30) / 6;
    return (x * t) >> 30;
  endfunction

  function automatic u64 cos_poly(u64 x);
    u64 x2, t;
    x2 = (x * x) >> 30;
    t = ONE_Q30 - x2 / 132;
    t = ONE_Q30 - ((x2 * t) >> 30) / 90;
    t = ONE_Q30 - ((x2 * t) >> 30) / 56;
    t = ONE_Q30 - ((x2 * t) >> 30) / 30;
    t = ONE_Q30 - ((x2 * t) >> 30) / 12;
    t = ONE_Q30 - ((x2 * t) >> 30) / 2;
    return t;
  endfunction

  // angle in 0.01 deg; magnitudes Q30 with sign flags
  task automatic trig_cdeg(input u64 a, output u64 s, output bit sn,
                           output u64 c, output bit cn);
    u64 q, rem, bs, bc;
    a = a % 36000;
    q = a / 9000;
    rem = a % 9000;
    if (rem <= 4500) begin
      bs = sin_poly(rem * RAD_PER_CDEG_Q30);
      bc = cos_poly(rem * RAD_PER_CDEG_Q30);
    end else begin
      bs = cos_poly((9000 - rem) * RAD_PER_CDEG_Q30);
      bc = sin_poly((9000 - rem) * RAD_PER_CDEG_Q30);
    end
    case (q)
      0: begin s = bs; sn = 0; c = bc; cn = 0; end
      1: begin s = bc; sn = 0; c = bs; cn = 1; end
      2: begin s = bs; sn = 1; c = bc; cn = 1; end
      default: begin s = bc; sn = 1; c = bs; cn = 0; end
    endcase
  endtask

  function automatic u64 log2_fix(u64 d);
    u64 e, m, frac;
    e = 0;
    frac = 0;
    while (e < 15 && (d >> (e + 1)) != 0) e++;
    m = d << (30 - e);
    for (int i = 0; i < 20; i++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (u64'(1) << 31)) begin
        m = m >> 1;
        frac = frac | 1;
      end
    end
    return (e << 20) | frac;
  endfunction

  function automatic logic [21:0] q8_to_q4(u64 mag, bit neg);
    u64 v;
    v = (mag + 8) >> 4;
    if (neg) v = 0 - v;
    return v[21:0];
  endfunction

  task automatic predict_point(input logic [7:0] ch, input logic [9:0] col,
                               input logic [15:0] d, output point_t p);
    longint r20;
    u64 r8, sp, cp, st, ct, zmag, rc, ang;
    bit spn, cpn, stn, ctn;
    int tl;
    p = '{x: '0, y: '0, z: '0, st: ST_OK};
    if (ch >= CHANNELS) begin
      p.st = ST_BADCH;
      return;
    end
    if (d == 0) begin
      p.st = ST_RANGE;
      return;
    end
    r20 = longint'(((u64'(d) * 11) << 20) / 10) + longint'(R_CONST_Q20)
        - longint'((log2_fix(d) * u64'(LOG2_COEF_Q16)) >> 16);
    if (r20 < 0) r20 = 0;
    if (r20 > (longint'(rmax) << 20) || r20 < (longint'(rmin) << 20)) begin
      p.st = ST_RANGE;
      return;
    end
    r8 = u64'(r20) >> 12;
    tl = int'($signed(tilt[ch[1:0]]));
    ang = u64'(tl < 0 ? tl + 36000 : tl);
    trig_cdeg(ang, sp, spn, cp, cpn);
    zmag = (r8 * sp) >> 30;
    if (gnd_on && tl != 0 && spn && zmag > (u64'(base_h) << 8)) begin
      p.st = ST_GROUND;
      return;
    end
    trig_cdeg((u64'(col) * 36000) / COLUMNS, st, stn, ct, ctn);
    rc = (r8 * cp) >> 30;
    p.x = q8_to_q4((rc * st) >> 30, stn != cpn);
    p.y = q8_to_q4((rc * ct) >> 30, ctn != cpn);
    p.z = q8_to_q4(zmag, spn);
  endtask

  always @(posedge clk) begin
    point_t p;
    if (rst) begin
      rmin <= '0;
      rmax <= 18'd100000;
      gnd_on <= 1'b0;
      base_h <= '0;
      for (int i = 0; i < 4; i++) tilt[i] <= '0;
      points_due.delete();
      errors <= 0;
      checked <= 0;
      pending <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_RANGE_MIN:   rmin <= cfg_data;
          REG_RANGE_MAX:   rmax <= cfg_data;
          REG_GROUND_ON:   gnd_on <= cfg_data[0];
          REG_BASE_HEIGHT: base_h <= cfg_data[15:0];
          REG_TILT0:       tilt[0] <= cfg_data[14:0];
          REG_TILT1:       tilt[1] <= cfg_data[14:0];
          REG_TILT2:       tilt[2] <= cfg_data[14:0];
          REG_TILT3:       tilt[3] <= cfg_data[14:0];
        endcase
      end
      if (start && !busy) begin
        predict_point(channel, column, distance_mm, p);
        points_due.insert(points_due.size(), p);
      end
      if (done) begin
        checked <= checked + 1;
        if (points_due.size() == 0) begin
          if (errors < 10) $display("ERROR: unexpected result at %0t", $realtime);
          errors <= errors + 1;
        end else begin
          p = points_due.pop_front();
          if (point_x !== p.x || point_y !== p.y || point_z !== p.z ||
              status !== p.st) begin
            if (errors < 10)
              $display("ERROR: got x=%0d y=%0d z=%0d st=%0d, want x=%0d y=%0d z=%0d st=%0d",
                       point_x, point_y, point_z, status, $signed(p.x),
                       $signed(p.y), $signed(p.z), p.st);
            errors <= errors + 1;
          end
        end
      end
      pending <= points_due.size();
    end
  end

endmodule

### verif/tb_lidar_sample_to_point.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lidar_sample_to_point: testbench for the lidar sample to point converter
// Directed corner samples, then random samples over several register
// settings and start-idle rates; lsp_checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_lidar_sample_to_point;
  import lsp_pkg::*;

  localparam int STALL_LIMIT = 4000;   // cycles with no transfer of any kind

  logic               clk, rst, start, busy;
  logic [7:0]         channel;
  logic [9:0]         column;
  logic [15:0]        distance_mm;
  logic               cfg_valid, cfg_ready;
  logic [2:0]         cfg_index;
  logic [17:0]        cfg_data;
  logic               done;
  logic signed [21:0] point_x, point_y, point_z;
  logic [1:0]         status;
  int                 errors, pending, checked;
  int                 quiet_cycles;
  int                 sent;

  lidar_sample_to_point uut (.*);

  lsp_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // watchdog: any transfer on any channel resets the count
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // one register write; block must be idle
  task automatic write_reg(input cfg_reg_t idx, input logic [17:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic write_tilt(input int ch, input int cdeg);
    write_reg(cfg_reg_t'(REG_TILT0 + ch), {3'b000, 15'(cdeg)});
  endtask

  task automatic setup(input int mn, input int mx, input bit gon, input int bh,
                       input int t0, input int t1, input int t2, input int t3);
    write_reg(REG_RANGE_MIN, 18'(mn));
    write_reg(REG_RANGE_MAX, 18'(mx));
    write_reg(REG_GROUND_ON, 18'(gon));
    write_reg(REG_BASE_HEIGHT, 18'(bh));
    write_tilt(0, t0);
    write_tilt(1, t1);
    write_tilt(2, t2);
    write_tilt(3, t3);
  endtask

  // presents one sample; start stays high afterwards, caller lowers it
  task automatic send_sample(input int idle_pct, input logic [7:0] ch,
                             input logic [9:0] col, input logic [15:0] d);
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    start       = 1'b1;
    channel     = ch;
    column      = col;
    distance_mm = d;
    do @(posedge clk); while (busy);
    @(negedge clk);
    sent++;
  endtask

  // all results back, then let the pipe drain before touching registers
  task automatic drain();
    start = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  task automatic random_samples(input int n, input int idle_pct);
    logic [7:0]  ch;
    logic [9:0]  col;
    logic [15:0] d;
    for (int i = 0; i < n; i++) begin
      // mostly good channels so the geometry gets exercised
      ch = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(3));
      col = ($urandom_range(9) == 0) ? 10'($urandom) : 10'($urandom_range(COLUMNS - 1));
      case ($urandom_range(3))
        0: d = 16'($urandom);
        1: d = 16'($urandom_range(2000));
        2: d = 16'($urandom_range(40000, 1000));
        default: d = ($urandom_range(7) == 0) ? 16'd0 : 16'($urandom_range(9000, 1));
      endcase
      send_sample(idle_pct, ch, col, d);
    end
  endtask

  initial begin
    int idle_rates [3] = '{0, 51, 24};
    rst = 1'b1;
    start = 1'b0;
    channel = '0;
    column = '0;
    distance_mm = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    sent = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: reset settings, field extremes, bad channels, zero distance,
    // column wrap and octant folds
    send_sample(0, 8'd0, 10'd0, 16'd0);
    send_sample(0, 8'd0, 10'd0, 16'd1);
    send_sample(0, 8'd1, 10'd899, 16'd65535);
    send_sample(0, 8'd2, 10'd225, 16'd1000);
    send_sample(0, 8'd3, 10'd112, 16'd5000);
    send_sample(0, 8'd3, 10'd113, 16'd5000);
    send_sample(0, 8'd4, 10'd0, 16'd100);
    send_sample(0, 8'd255, 10'd1023, 16'd65535);
    send_sample(0, 8'd0, 10'd1023, 16'd2);
    send_sample(0, 8'd1, 10'd450, 16'd32768);
    send_sample(0, 8'd2, 10'd675, 16'd100);
    drain();

    // ground removal with steep negative tilts and tilts past +-90 deg
    setup(0, 200000, 1'b1, 0, -9000, -16384, 16383, 9000);
    send_sample(0, 8'd0, 10'd10, 16'd3000);
    send_sample(0, 8'd1, 10'd20, 16'd3000);
    send_sample(0, 8'd2, 10'd30, 16'd65535);
    send_sample(0, 8'd3, 10'd40, 16'd1);
    drain();
    setup(0, 200000, 1'b1, 65535, -100, -4500, 0, -1);
    send_sample(0, 8'd0, 10'd300, 16'd65535);
    send_sample(0, 8'd1, 10'd600, 16'd65535);
    send_sample(0, 8'd2, 10'd899, 16'd40000);
    send_sample(0, 8'd3, 10'd1, 16'd20);
    drain();

    // random phases over a range of settings, extremes among them
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: setup(0, 200000, 1'b0, 0, 0, 1500, -1500, 9000);
        1: setup(5000, 40000, 1'b1, 1000, -9000, -2000, 0, 3000);
        2: setup(0, 0, 1'b1, 0, -300, 300, -9000, 0);
        3: setup(200000, 200000, 1'b0, 65535, 1, -1, 2, -2);
        4: setup(1000, 70000, 1'b1, 65535, -16384, 16383, -12000, 4500);
        default: setup($urandom_range(3000), $urandom_range(200000, 20000),
                       1'($urandom), $urandom_range(3000),
                       $urandom_range(18000) - 9000, $urandom_range(18000) - 9000,
                       int'($signed(15'($urandom))), $urandom_range(9000) - 9000);
      endcase
      random_samples(245, idle_rates[ph % 3]);
      drain();
    end

    $display("Sent %0d samples, checked %0d results over reset, ground, range", sent,
             checked);
    $display("and random register settings with start idle rates of 0, 24 and 51 pct");
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
